### rtl/core/battery_block_average_monitor_defines.svh
// assertion macros shared by the battery block average monitor checkers
`ifndef BATTERY_BLOCK_AVERAGE_MONITOR_DEFINES_SVH
`define BATTERY_BLOCK_AVERAGE_MONITOR_DEFINES_SVH

// plain clocked assertion, also active while reset is asserted
`define BBAM_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion that is switched off while the active-low reset is low
`define BBAM_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### rtl/core/bbam_pkg.sv
// shared types and constants of the battery block average monitor
`timescale 1ns / 1ps
`default_nettype none

package bbam_pkg;

    localparam int SAMPLES_DEFAULT  = 5;
    localparam int ADC_BITS_DEFAULT = 10;

    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 17;
    localparam int THRESH_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CUR_W      = 18;
    localparam int VOLT_W     = 17;
    localparam int Q8_SHIFT   = 8;

    // queue depths, powers of two
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 8;

    localparam logic        [GAIN_W-1:0]   CUR_GAIN_RST   = 16'd32074;
    localparam logic signed [OFFSET_W-1:0] CUR_OFFSET_RST = -17'sd12830;
    localparam logic        [GAIN_W-1:0]   VOLT_GAIN_RST  = 16'd9900;
    localparam logic        [THRESH_W-1:0] WARNING_RST    = 17'd0;

    // lanes of the scaling pipeline
    localparam int LANE_CUR  = 0;
    localparam int LANE_VOLT = 1;
    localparam int LANES     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_GAIN   = 2'd0,
        CFG_CUR_OFFSET = 2'd1,
        CFG_VOLT_GAIN  = 2'd2,
        CFG_WARNING    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0]   cur_gain;
        logic signed [OFFSET_W-1:0] cur_offset;
        logic        [GAIN_W-1:0]   volt_gain;
        logic        [THRESH_W-1:0] warning;
    } t_cfg;

    typedef struct packed {
        logic signed [CUR_W-1:0]  current_ma;
        logic        [VOLT_W-1:0] voltage_mv;
        logic                     low_voltage;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/bbam_fifo.sv
// small synchronous fifo with show-ahead read
`timescale 1ns / 1ps
`default_nettype none

module bbam_fifo import bbam_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bbam_cfg.sv
// configuration register file of the battery block average monitor
`timescale 1ns / 1ps
`default_nettype none

module bbam_cfg import bbam_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_cfg_idx cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cur_gain   <= CUR_GAIN_RST;
            r_cfg.cur_offset <= CUR_OFFSET_RST;
            r_cfg.volt_gain  <= VOLT_GAIN_RST;
            r_cfg.warning    <= WARNING_RST;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_CUR_GAIN:   r_cfg.cur_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_CUR_OFFSET: r_cfg.cur_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                CFG_VOLT_GAIN:  r_cfg.volt_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_WARNING:    r_cfg.warning    <= i_cfg_data[THRESH_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/bbam_front.sv
// front end: accepts sample pairs and accumulates one block of sums
`timescale 1ns / 1ps
`default_nettype none

module bbam_front import bbam_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT,
    parameter int ADC_BITS            = ADC_BITS_DEFAULT,
    parameter int SUM_W               = ADC_BITS_DEFAULT + 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [ADC_BITS-1:0]   i_current_count,
    input  wire logic [ADC_BITS-1:0]   i_voltage_count,
    output logic                       o_full,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output logic      [2*SUM_W-1:0]    o_q_data
);

    localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_cur_sum;
    logic [SUM_W-1:0] r_volt_sum;
    logic [SUM_W-1:0] n_cur_sum;
    logic [SUM_W-1:0] n_volt_sum;
    logic             last;
    logic             accept;

    // only the item that closes a block needs room in the queue
    assign last       = (r_count == LAST);
    assign o_full     = i_q_full && last;
    assign accept     = i_push && !o_full;
    assign n_cur_sum  = r_cur_sum + SUM_W'(i_current_count);
    assign n_volt_sum = r_volt_sum + SUM_W'(i_voltage_count);
    assign o_q_push   = accept && last;
    assign o_q_data   = {n_cur_sum, n_volt_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cur_sum  <= '0;
            r_volt_sum <= '0;
        end else if (accept) begin
            if (last) begin
                r_count    <= '0;
                r_cur_sum  <= '0;
                r_volt_sum <= '0;
            end else begin
                r_count    <= r_count + CNT_W'(1);
                r_cur_sum  <= n_cur_sum;
                r_volt_sum <= n_volt_sum;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/bbam_back.sv
// back end: scales block sums to averages, rounds, saturates and flags
`timescale 1ns / 1ps
`default_nettype none

module bbam_back import bbam_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT,
    parameter int SUM_W               = ADC_BITS_DEFAULT + 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_q_empty,
    input  wire logic [2*SUM_W-1:0]   i_q_data,
    output logic                      o_q_pop,
    input  wire logic                 i_out_pop,
    output logic                      o_res_valid,
    output t_result                   o_res
);

    localparam int STAGES  = 5;
    localparam int CRED_W  = $clog2(OUT_DEPTH + 1);
    localparam int P_W     = GAIN_W + SUM_W;
    localparam int YW      = P_W + 1 - Q8_SHIFT;
    localparam int RECIP_W = YW + 1;
    localparam int T_W     = YW + RECIP_W;
    localparam int CW      = YW + 2;
    localparam int HALF    = (1 << (Q8_SHIFT - 1)) * SAMPLES_PER_AVERAGE;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((longint'(1) << YW) / SAMPLES_PER_AVERAGE);
    localparam logic [YW-1:0]          N_Y     = YW'(SAMPLES_PER_AVERAGE);
    localparam logic signed [CW-1:0]   CUR_HI  = CW'((2 ** (CUR_W - 1)) - 1);
    localparam logic signed [CW-1:0]   CUR_LO  = CW'(-(2 ** (CUR_W - 1)));
    localparam logic [VOLT_W-1:0]      VOLT_MAX = '1;

    logic [SUM_W-1:0]  sum_in  [LANES];
    logic [GAIN_W-1:0] gain    [LANES];
    logic [P_W:0]      rounded [LANES];
    logic [YW-1:0]     q0      [LANES];
    logic [YW-1:0]     rem     [LANES];

    logic [P_W-1:0]    r_prod  [LANES];
    logic [YW-1:0]     r_y     [LANES];
    logic [T_W-1:0]    r_t     [LANES];
    logic [YW-1:0]     r_y3    [LANES];
    logic [YW-1:0]     r_q     [LANES];

    logic [STAGES-1:0] r_vld;
    logic [CRED_W-1:0] r_used;
    logic [CRED_W-1:0] n_used;
    logic              issue;

    logic signed [CW-1:0] cur_full;
    logic [VOLT_W-1:0]    volt_sat;
    t_result              n_res;
    t_result              r_res;

    assign sum_in[LANE_CUR]  = i_q_data[2*SUM_W-1:SUM_W];
    assign sum_in[LANE_VOLT] = i_q_data[SUM_W-1:0];
    assign gain[LANE_CUR]    = i_cfg.cur_gain;
    assign gain[LANE_VOLT]   = i_cfg.volt_gain;

    // a block enters only if the result queue is sure to have room for it
    assign issue   = !i_q_empty && (r_used < CRED_W'(OUT_DEPTH));
    assign o_q_pop = issue;
    assign n_used  = r_used + CRED_W'(issue) - CRED_W'(i_out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_used <= '0;
        end else begin
            r_vld  <= {r_vld[STAGES-2:0], issue};
            r_used <= n_used;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rounded[l] = {1'b0, r_prod[l]} + (P_W + 1)'(HALF);
            q0[l]      = r_t[l][YW +: YW];
            rem[l]     = r_y3[l] - q0[l] * N_Y;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_prod[l] <= P_W'(gain[l]) * P_W'(sum_in[l]);
            r_y[l]    <= rounded[l][P_W:Q8_SHIFT];
            r_t[l]    <= T_W'(r_y[l]) * T_W'(RECIP);
            r_y3[l]   <= r_y[l];
            // reciprocal estimate is low by at most one
            r_q[l]    <= q0[l] + YW'(rem[l] >= N_Y);
        end
    end

    always_comb begin
        cur_full = $signed({2'b00, r_q[LANE_CUR]}) + CW'($signed(i_cfg.cur_offset));
        priority if (cur_full > CUR_HI) begin
            n_res.current_ma = CUR_HI[CUR_W-1:0];
        end else if (cur_full < CUR_LO) begin
            n_res.current_ma = CUR_LO[CUR_W-1:0];
        end else begin
            n_res.current_ma = cur_full[CUR_W-1:0];
        end
        if (r_q[LANE_VOLT] > YW'(VOLT_MAX)) begin
            volt_sat = VOLT_MAX;
        end else begin
            volt_sat = r_q[LANE_VOLT][VOLT_W-1:0];
        end
        n_res.voltage_mv  = volt_sat;
        n_res.low_voltage = (volt_sat <= i_cfg.warning);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_vld[STAGES-1];
    assign o_res       = r_res;

endmodule

`default_nettype wire

### rtl/core/battery_block_average_monitor.sv
// top level of the battery block average monitor
`timescale 1ns / 1ps
`default_nettype none

// battery block average monitor
// - input channel is a queue write side: a current/voltage count pair is one
//   transaction, taken when push is high and full is low, one per cycle
// - the front end sums SAMPLES_PER_AVERAGE pairs; the pair that closes a block
//   hands both sums to a two-entry queue, all other pairs cause no result
// - the back end is a five stage pipeline per channel: gain multiply, half-up
//   rounding and drop of the q8 bits, reciprocal multiply for the divide by
//   the block size, one-step quotient correction, offset add with saturation
//   and the low voltage compare
// - results sit in an eight-entry queue; empty low shows the oldest one and
//   pop takes it; the closing pair's sums reach it through the middle queue and the back end
// - throughput is one pair per cycle and one result per block; the back end
//   only starts a block when the result queue has a guaranteed slot, so a
//   stalled reader fills the result queue, then the middle queue, and then
//   full rises on the pair that would close the next block
// - config port: valid/ready write of one register per transaction, ready is
//   always high; write only while no block is in flight
// - reset (synchronous, active low) clears the sums, queues and pipeline and
//   loads the register defaults; no items are lost after reset is released
module battery_block_average_monitor import bbam_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT,
    parameter int ADC_BITS            = ADC_BITS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample input
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [ADC_BITS-1:0]    i_current_count,
    input  wire logic [ADC_BITS-1:0]    i_voltage_count,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // result output
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [CUR_W-1:0]     o_avg_current_ma,
    output logic        [VOLT_W-1:0]    o_avg_voltage_mv,
    output logic                        o_low_voltage
);

    // sums never wrap for any block size
    localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RES_W = $bits(t_result);

    t_cfg               cfg;
    logic               mid_push;
    logic [2*SUM_W-1:0] mid_wdata;
    logic               mid_full;
    logic               mid_pop;
    logic [2*SUM_W-1:0] mid_rdata;
    logic               mid_empty;
    logic               res_valid;
    t_result            res;
    logic [RES_W-1:0]   out_rdata;
    logic               out_pop;
    t_result            out_res;

    assign out_pop = pop && !empty;

    bbam_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    bbam_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .ADC_BITS            (ADC_BITS),
        .SUM_W               (SUM_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_current_count (i_current_count),
        .i_voltage_count (i_voltage_count),
        .o_full          (full),
        .i_q_full        (mid_full),
        .o_q_push        (mid_push),
        .o_q_data        (mid_wdata)
    );

    // block sums waiting for the back end
    bbam_fifo #(
        .WIDTH (2 * SUM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty)
    );

    bbam_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SUM_W               (SUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (mid_empty),
        .i_q_data    (mid_rdata),
        .o_q_pop     (mid_pop),
        .i_out_pop   (out_pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // finished results; the back end's credit count keeps this from overflowing
    bbam_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (),
        .i_pop   (out_pop),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign out_res          = t_result'(out_rdata);
    assign o_avg_current_ma = out_res.current_ma;
    assign o_avg_voltage_mv = out_res.voltage_mv;
    assign o_low_voltage    = out_res.low_voltage;

endmodule

`default_nettype wire

### rtl/core/bbam_checker.sv
// port-level checker of the battery block average monitor, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "battery_block_average_monitor_defines.svh"

module bbam_checker import bbam_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     push,
    input wire logic                     full,
    input wire logic                     empty,
    input wire logic                     pop,
    input wire logic signed [CUR_W-1:0]  o_avg_current_ma,
    input wire logic        [VOLT_W-1:0] o_avg_voltage_mv,
    input wire logic                     o_low_voltage
);

    localparam int CNT_W  = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int OWED_W = $clog2(MID_DEPTH + OUT_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic [CNT_W-1:0]  r_phase;
    logic [OWED_W-1:0] r_owed;
    logic              accepted;
    logic              popped;
    logic              block_done;

    assign accepted   = push && !full;
    assign popped     = pop && !empty;
    assign block_done = accepted && (r_phase == LAST);

    // closed blocks whose result has not yet been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_owed  <= '0;
        end else begin
            if (accepted) begin
                r_phase <= block_done ? '0 : r_phase + CNT_W'(1);
            end
            r_owed <= r_owed + OWED_W'(block_done) - OWED_W'(popped);
        end
    end

    `BBAM_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> empty, "result queue not empty after reset")
    `BBAM_ASSERT_RST(a_no_extra_result, i_clk, i_rst_n, !empty |-> r_owed != '0, "result shown with no closed block")
    `BBAM_ASSERT_RST(a_full_when_idle, i_clk, i_rst_n, r_owed == '0 |-> !full, "full raised with nothing in flight")
    `BBAM_ASSERT_RST(a_result_held, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_avg_current_ma) && $stable(o_avg_voltage_mv) && $stable(o_low_voltage), "waiting result changed before pop")

endmodule

bind battery_block_average_monitor bbam_checker #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
) u_bbam_checker (.*);

`default_nettype wire
